// ===== hw/rtl/esp_pkg.sv =====
package esp_pkg;

   // Sizes of the worker and task tables.
   localparam int unsigned WORKERS   = 8;
   localparam int unsigned WIDX_BITS = 3;
   localparam int unsigned TASKS     = 256;
   localparam int unsigned TIDX_BITS = 8;
   localparam int unsigned TIME_BITS = 48;

   // Request kinds carried on the input tuser.
   localparam logic [2:0] FUNC_LOAD  = 3'd0;
   localparam logic [2:0] FUNC_BEGIN = 3'd1;
   localparam logic [2:0] FUNC_DEP   = 3'd2;
   localparam logic [2:0] FUNC_MODEL = 3'd3;
   localparam logic [2:0] FUNC_PLACE = 3'd4;

   // Register indexes on the csr port.
   localparam logic CSR_BASE_TIME    = 1'b0;
   localparam logic CSR_WORKER_COUNT = 1'b1;

   // Fixed-point reciprocals (0.32, held in 30 bits) of the transfer rates.
   localparam logic [29:0] RECIP_H2G   = 30'd871489361;
   localparam logic [29:0] RECIP_G2H   = 30'd871489;
   localparam logic [29:0] RECIP_C2C   = 30'd341333;
   localparam logic [31:0] FIXED_COST  = 32'd2;
   localparam logic [31:0] SMALL_LIMIT = 32'd4;

   typedef logic [TIME_BITS-1:0] time_type;

   // One worker entry as held in the worker memory.
   typedef struct packed {
      time_type    free_time;
      logic [15:0] cache;
      time_type    start_acc;
      time_type    fetch_acc;
   } worker_rec_type;

   // Access request toward the worker memory.
   typedef struct packed {
      logic                 rd_en;
      logic [WIDX_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [WIDX_BITS-1:0] wr_addr;
   } wm_req_type;

   // Adds two times, saturating at the largest time.
   function automatic time_type sat_add(time_type a, time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

endpackage

// ===== hw/rtl/esp_worker_mem.sv =====
module esp_worker_mem (
   input  logic                                   clock,
   input  logic                                   reset,
   input  esp_pkg::wm_req_type                    req,
   input  esp_pkg::worker_rec_type                wr_data,
   output esp_pkg::worker_rec_type                rd_data
);

   esp_pkg::worker_rec_type          mem [esp_pkg::WORKERS];
   logic [esp_pkg::WORKERS-1:0]      valid_ff;
   esp_pkg::worker_rec_type          raw_ff;
   logic                             raw_valid_ff;

   // Entries that were never written read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   // Synchronous memory, one write and one registered read.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= wr_data;
      end
      if (req.rd_en) begin
         raw_ff       <= mem[req.rd_addr];
         raw_valid_ff <= valid_ff[req.rd_addr];
      end
   end

   assign rd_data = raw_valid_ff ? raw_ff : '0;

endmodule

// ===== hw/rtl/esp_task_mem.sv =====
module esp_task_mem (
   input  logic                                clock,
   input  logic [esp_pkg::TIDX_BITS-1:0]       rd_addr,
   input  logic                                size_wr_en,
   input  logic [esp_pkg::TIDX_BITS-1:0]       size_wr_addr,
   input  logic [31:0]                         size_wr_data,
   input  logic                                res_wr_en,
   input  logic [esp_pkg::TIDX_BITS-1:0]       res_wr_addr,
   input  logic [esp_pkg::WIDX_BITS-1:0]       res_wr_worker,
   input  esp_pkg::time_type                   res_wr_finish,
   output logic [31:0]                         rd_size,
   output logic [esp_pkg::WIDX_BITS-1:0]       rd_worker,
   output esp_pkg::time_type                   rd_finish
);

   logic [31:0]                   size_mem   [esp_pkg::TASKS];
   logic [esp_pkg::WIDX_BITS-1:0] worker_mem [esp_pkg::TASKS];
   esp_pkg::time_type             finish_mem [esp_pkg::TASKS];

   // Output size is written when a task opens.
   always_ff @(posedge clock) begin
      if (size_wr_en) begin
         size_mem[size_wr_addr] <= size_wr_data;
      end
      rd_size <= size_mem[rd_addr];
   end

   // Worker and finish time are written when a task is placed.
   always_ff @(posedge clock) begin
      if (res_wr_en) begin
         worker_mem[res_wr_addr] <= res_wr_worker;
         finish_mem[res_wr_addr] <= res_wr_finish;
      end
      rd_worker <= worker_mem[rd_addr];
      rd_finish <= finish_mem[rd_addr];
   end

endmodule

// ===== hw/rtl/earliest_start_task_placer.sv =====
// Each word is taken in the idle state and finished before the next is taken.
// Load: prep, then a sweep of its own worker. Begin and model: multiply, prep, a sweep
// of all workers. Dependency: task-table read first; it ends there when the prerequisite
// was never placed. Place: prep, a sweep of the n workers (worker_count held to 1..8), the
// write-back, then the emit step, which holds the result back while the previous one waits.
// Synchronous reset clears the worker table, the placed flags and the open task.
module earliest_start_task_placer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // worker_index, queue_wait, cache_mask, task_index, run_time, result_size,
   // is_first, prereq_index, model_id, model_size (from bit 0 up)
   input  logic [167:0] req_tdata,
   // func
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // assigned_worker, end_time, missing_dependency (from bit 0 up)
   output logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [47:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_TREAD, ST_MUL, ST_PREP, ST_SWEEP, ST_PWR, ST_EMIT
   } state_type;

   localparam int unsigned WB = esp_pkg::WIDX_BITS;
   localparam int unsigned TB = esp_pkg::TIDX_BITS;

   // Input fields.
   logic [2:0]  in_worker;
   logic [31:0] in_wait;
   logic [15:0] in_mask;
   logic [7:0]  in_task;
   logic [31:0] in_exec;
   logic [31:0] in_osize;
   logic        in_first;
   logic [7:0]  in_prereq;
   logic [3:0]  in_model;
   logic [30:0] in_msize;

   assign in_worker = req_tdata[2:0];
   assign in_wait   = req_tdata[34:3];
   assign in_mask   = req_tdata[50:35];
   assign in_task   = req_tdata[58:51];
   assign in_exec   = req_tdata[90:59];
   assign in_osize  = req_tdata[122:91];
   assign in_first  = req_tdata[123];
   assign in_prereq = req_tdata[131:124];
   assign in_model  = req_tdata[135:132];
   assign in_msize  = req_tdata[166:136];

   state_type          state_ff;
   esp_pkg::time_type  base_ff;
   logic [3:0]         count_ff;
   logic [2:0]         func_ff;
   logic [WB-1:0]      widx_ff;
   logic [31:0]        wait_ff;
   logic [15:0]        mask_ff;
   logic               first_ff;
   logic [3:0]         model_ff;
   logic [31:0]        op_ff;
   logic [1:0]         mstep_ff;
   logic [61:0]        prod_ff;
   logic [31:0]        acc_ff;
   esp_pkg::time_type  pfin_ff;
   logic [WB-1:0]      pwk_ff;
   esp_pkg::time_type  start_val_ff;
   logic [TB-1:0]      open_index_ff;
   logic [31:0]        open_exec_ff;
   logic               open_missing_ff;
   logic [esp_pkg::TASKS-1:0] placed_ff;
   logic               placed_rd_ff;
   logic               rd_act_ff;
   logic [WB-1:0]      rd_idx_ff;
   logic [WB-1:0]      hi_ff;
   logic               wr_act_ff;
   logic [WB-1:0]      wr_idx_ff;
   logic               best_first_ff;
   esp_pkg::time_type  best_s_ff;
   logic [WB-1:0]      best_idx_ff;
   esp_pkg::worker_rec_type best_rec_ff;
   esp_pkg::time_type  fin_ff;
   logic               rsp_valid_ff;
   logic [55:0]        rsp_data_ff;

   logic                    accept;
   logic [1:0]              mcount;
   logic [29:0]             recip;
   logic [31:0]             term;
   esp_pkg::wm_req_type     wm_req;
   esp_pkg::worker_rec_type wm_rd;
   esp_pkg::worker_rec_type wm_wr;
   esp_pkg::worker_rec_type upd;
   esp_pkg::time_type       arrive;
   esp_pkg::time_type       cand;
   esp_pkg::time_type       fin;
   logic [WB-1:0]           count_hi;
   logic [31:0]             tm_size;
   logic [WB-1:0]           tm_worker;
   esp_pkg::time_type       tm_finish;
   logic                    emit_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign emit_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Clamped last worker index for placement.
   always_comb begin
      priority if (count_ff == 4'd0) begin
         count_hi = '0;
      end else if (count_ff > 4'(esp_pkg::WORKERS)) begin
         count_hi = WB'(esp_pkg::WORKERS - 1);
      end else begin
         count_hi = WB'(count_ff - 4'd1);
      end
   end

   // Reciprocal for each multiply step: g2h, c2c, h2g for dependencies, h2g otherwise.
   assign mcount = (func_ff == esp_pkg::FUNC_DEP) ? 2'd3 : 2'd1;
   always_comb begin
      if (func_ff == esp_pkg::FUNC_DEP) begin
         unique case (mstep_ff)
            2'd0:    recip = esp_pkg::RECIP_G2H;
            2'd1:    recip = esp_pkg::RECIP_C2C;
            default: recip = esp_pkg::RECIP_H2G;
         endcase
      end else begin
         recip = esp_pkg::RECIP_H2G;
      end
   end

   // Delay term from the previous product; c2c of tiny sizes is the fixed cost.
   always_comb begin
      if (func_ff == esp_pkg::FUNC_DEP && mstep_ff == 2'd2 && op_ff < esp_pkg::SMALL_LIMIT) begin
         term = esp_pkg::FIXED_COST;
      end else begin
         term = {2'b00, prod_ff[61:32]} + esp_pkg::FIXED_COST;
      end
   end

   // Per-worker update at the write stage of the sweep.
   always_comb begin
      upd    = wm_rd;
      arrive = (wr_idx_ff == pwk_ff) ? pfin_ff
             : esp_pkg::sat_add(pfin_ff, esp_pkg::time_type'(acc_ff));
      cand   = esp_pkg::sat_add((wm_rd.start_acc > wm_rd.free_time) ? wm_rd.start_acc
                                                                      : wm_rd.free_time,
                                wm_rd.fetch_acc);
      unique case (func_ff)
         esp_pkg::FUNC_LOAD: begin
            upd.free_time = esp_pkg::sat_add(base_ff, esp_pkg::time_type'(wait_ff));
            upd.cache     = mask_ff;
         end
         esp_pkg::FUNC_BEGIN: begin
            upd.start_acc = start_val_ff;
            upd.fetch_acc = '0;
         end
         esp_pkg::FUNC_DEP: begin
            if (arrive > wm_rd.start_acc) begin
               upd.start_acc = arrive;
            end
         end
         esp_pkg::FUNC_MODEL: begin
            if (!wm_rd.cache[model_ff]) begin
               upd.fetch_acc = esp_pkg::sat_add(wm_rd.fetch_acc,
                                                esp_pkg::time_type'(acc_ff));
            end
         end
         default: begin
            upd = wm_rd;
         end
      endcase
   end

   assign fin = esp_pkg::sat_add(best_s_ff, esp_pkg::time_type'(open_exec_ff));

   // Worker memory access: sweep reads and writes, placement write-back.
   always_comb begin
      wm_req.rd_en   = rd_act_ff;
      wm_req.rd_addr = rd_idx_ff;
      wm_req.wr_en   = 1'b0;
      wm_req.wr_addr = wr_idx_ff;
      wm_wr          = upd;
      if (state_ff == ST_SWEEP) begin
         wm_req.wr_en = wr_act_ff && (func_ff != esp_pkg::FUNC_PLACE);
      end else if (state_ff == ST_PWR) begin
         wm_req.wr_en     = 1'b1;
         wm_req.wr_addr   = best_idx_ff;
         wm_wr            = best_rec_ff;
         wm_wr.free_time  = fin;
      end
   end

   esp_worker_mem u_wmem (
      .clock   (clock),
      .reset   (reset),
      .req     (wm_req),
      .wr_data (wm_wr),
      .rd_data (wm_rd)
   );

   esp_task_mem u_tmem (
      .clock         (clock),
      .rd_addr       (in_prereq),
      .size_wr_en    (accept && req_tuser == esp_pkg::FUNC_BEGIN),
      .size_wr_addr  (in_task),
      .size_wr_data  (in_osize),
      .res_wr_en     (state_ff == ST_PWR),
      .res_wr_addr   (open_index_ff),
      .res_wr_worker (best_idx_ff),
      .res_wr_finish (fin),
      .rd_size       (tm_size),
      .rd_worker     (tm_worker),
      .rd_finish     (tm_finish)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         count_ff <= 4'd8;
      end else if (csr_we) begin
         unique case (csr_index)
            esp_pkg::CSR_BASE_TIME:    base_ff  <= csr_wdata;
            esp_pkg::CSR_WORKER_COUNT: count_ff <= csr_wdata[3:0];
            default:                   base_ff  <= base_ff;
         endcase
      end
   end

   // Sequencer: state and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         open_index_ff   <= '0;
         open_exec_ff    <= '0;
         open_missing_ff <= 1'b0;
         placed_ff       <= '0;
         rd_act_ff       <= 1'b0;
         wr_act_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         wr_act_ff    <= rd_act_ff;
         wr_idx_ff    <= rd_idx_ff;
         placed_rd_ff <= placed_ff[in_prereq];
         if (rsp_valid_ff && rsp_tready && !emit_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  func_ff  <= req_tuser;
                  widx_ff  <= in_worker;
                  wait_ff  <= in_wait;
                  mask_ff  <= in_mask;
                  first_ff <= in_first;
                  model_ff <= in_model;
                  acc_ff   <= '0;
                  mstep_ff <= '0;
                  unique case (req_tuser)
                     esp_pkg::FUNC_LOAD, esp_pkg::FUNC_PLACE: begin
                        state_ff <= ST_PREP;
                     end
                     esp_pkg::FUNC_BEGIN: begin
                        op_ff           <= in_osize;
                        open_index_ff   <= in_task;
                        open_exec_ff    <= in_exec;
                        open_missing_ff <= 1'b0;
                        state_ff        <= ST_MUL;
                     end
                     esp_pkg::FUNC_MODEL: begin
                        op_ff    <= {1'b0, in_msize};
                        state_ff <= ST_MUL;
                     end
                     esp_pkg::FUNC_DEP: begin
                        state_ff <= ST_TREAD;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_TREAD: begin
               // A prerequisite that was never placed only marks the open task.
               if (placed_rd_ff) begin
                  op_ff    <= tm_size;
                  pfin_ff  <= tm_finish;
                  pwk_ff   <= tm_worker;
                  state_ff <= ST_MUL;
               end else begin
                  open_missing_ff <= 1'b1;
                  state_ff        <= ST_IDLE;
               end
            end
            ST_MUL: begin
               // One product a cycle, each summed in the cycle after.
               prod_ff <= op_ff * recip;
               if (mstep_ff != 2'd0) begin
                  acc_ff <= acc_ff + term;
               end
               mstep_ff <= mstep_ff + 2'd1;
               if (mstep_ff == mcount) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               start_val_ff  <= esp_pkg::sat_add(base_ff, first_ff
                                   ? esp_pkg::time_type'(acc_ff) : '0);
               best_first_ff <= 1'b1;
               rd_act_ff     <= 1'b1;
               if (func_ff == esp_pkg::FUNC_LOAD) begin
                  rd_idx_ff <= widx_ff;
                  hi_ff     <= widx_ff;
               end else if (func_ff == esp_pkg::FUNC_PLACE) begin
                  rd_idx_ff <= '0;
                  hi_ff     <= count_hi;
               end else begin
                  rd_idx_ff <= '0;
                  hi_ff     <= WB'(esp_pkg::WORKERS - 1);
               end
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (rd_act_ff) begin
                  rd_idx_ff <= rd_idx_ff + 1'b1;
                  if (rd_idx_ff == hi_ff) begin
                     rd_act_ff <= 1'b0;
                  end
               end
               if (wr_act_ff) begin
                  // Least start time wins, lowest index on ties.
                  if (best_first_ff || cand < best_s_ff) begin
                     best_s_ff   <= cand;
                     best_idx_ff <= wr_idx_ff;
                     best_rec_ff <= wm_rd;
                  end
                  best_first_ff <= 1'b0;
                  if (wr_idx_ff == hi_ff) begin
                     state_ff <= (func_ff == esp_pkg::FUNC_PLACE) ? ST_PWR : ST_IDLE;
                  end
               end
            end
            ST_PWR: begin
               fin_ff                   <= fin;
               placed_ff[open_index_ff] <= 1'b1;
               state_ff                 <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {4'b0000, open_missing_ff, fin_ff, best_idx_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A result only appears after a placement reached the emit step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside placement");

   // The worker table is never written while the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wm_req.wr_en)
      else $error("worker write while idle");

   // Opening a task clears its missing-dependency flag.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == esp_pkg::FUNC_BEGIN) |=> !open_missing_ff)
      else $error("missing flag survived a begin");

endmodule

// ===== bench/esp_checker.sv =====
`timescale 1ns / 100ps

module esp_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [167:0] req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [55:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [47:0]  csr_wdata,
   output int           fail_count,
   output int           pending
);

   // One placement result as it leaves the block.
   typedef struct packed {
      logic              missing;
      esp_pkg::time_type finish;
      logic [2:0]        worker;
   } placement_type;

   // Shadow copy of the block's state.
   esp_pkg::time_type base_time_q;
   logic [3:0]        worker_count_q;
   esp_pkg::time_type free_time [esp_pkg::WORKERS];
   logic [15:0]       cache_mask [esp_pkg::WORKERS];
   esp_pkg::time_type start_acc [esp_pkg::WORKERS];
   esp_pkg::time_type fetch_acc [esp_pkg::WORKERS];
   logic [2:0]        task_worker [esp_pkg::TASKS];
   esp_pkg::time_type task_finish [esp_pkg::TASKS];
   logic [31:0]       task_out_size [esp_pkg::TASKS];
   logic              task_placed [esp_pkg::TASKS];
   logic [7:0]        open_index;
   logic [31:0]       open_exec;
   logic              open_missing;

   placement_type placements_due[$];

   assign pending = placements_due.size();

   function automatic esp_pkg::time_type add_sat(esp_pkg::time_type a, esp_pkg::time_type b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? '1 : s[47:0];
   endfunction

   function automatic esp_pkg::time_type host_to_gpu(logic [31:0] s);
      logic [63:0] p;
      p = 64'(s) * 64'd871489361;
      return esp_pkg::time_type'(p >> 32) + 48'd2;
   endfunction

   function automatic esp_pkg::time_type gpu_to_gpu(logic [31:0] s);
      logic [63:0] g2h, c2c;
      g2h = ((64'(s) * 64'd871489) >> 32) + 64'd2;
      c2c = (s < 4) ? 64'd2 : ((64'(s) * 64'd341333) >> 32) + 64'd2;
      return esp_pkg::time_type'(g2h + c2c) + host_to_gpu(s);
   endfunction

   // Applies one accepted request word to the shadow state.
   task automatic apply_request(logic [2:0] func, logic [167:0] d);
      logic [2:0]  wi;
      logic [7:0]  p;
      logic [3:0]  id;
      logic [31:0] osz;
      esp_pkg::time_type start, arrive, fetch, s, best_start;
      int          count, best;
      wi = d[2:0];
      case (func)
         esp_pkg::FUNC_LOAD: begin
            free_time[wi] = add_sat(base_time_q, 48'(d[34:3]));
            cache_mask[wi] = d[50:35];
         end
         esp_pkg::FUNC_BEGIN: begin
            open_index = d[58:51];
            open_exec = d[90:59];
            osz = d[122:91];
            open_missing = 1'b0;
            task_out_size[open_index] = osz;
            start = base_time_q;
            if (d[123]) start = add_sat(start, host_to_gpu(osz));
            for (int w = 0; w < esp_pkg::WORKERS; w++) begin
               start_acc[w] = start;
               fetch_acc[w] = '0;
            end
         end
         esp_pkg::FUNC_DEP: begin
            p = d[131:124];
            if (!task_placed[p]) begin
               open_missing = 1'b1;
            end else begin
               for (int w = 0; w < esp_pkg::WORKERS; w++) begin
                  arrive = task_finish[p];
                  if (w != task_worker[p])
                     arrive = add_sat(arrive, gpu_to_gpu(task_out_size[p]));
                  if (arrive > start_acc[w]) start_acc[w] = arrive;
               end
            end
         end
         esp_pkg::FUNC_MODEL: begin
            id = d[135:132];
            fetch = host_to_gpu({1'b0, d[166:136]});
            for (int w = 0; w < esp_pkg::WORKERS; w++)
               if (!cache_mask[w][id]) fetch_acc[w] = add_sat(fetch_acc[w], fetch);
         end
         esp_pkg::FUNC_PLACE: begin
            count = int'(worker_count_q);
            if (count < 1) count = 1;
            if (count > esp_pkg::WORKERS) count = esp_pkg::WORKERS;
            best = 0;
            best_start = '0;
            for (int w = 0; w < count; w++) begin
               s = free_time[w] > start_acc[w] ? free_time[w] : start_acc[w];
               s = add_sat(s, fetch_acc[w]);
               if (w == 0 || s < best_start) begin
                  best_start = s;
                  best = w;
               end
            end
            s = add_sat(best_start, 48'(open_exec));
            task_worker[open_index] = 3'(best);
            task_finish[open_index] = s;
            task_placed[open_index] = 1'b1;
            free_time[best] = s;
            placements_due.push_back({open_missing, s, 3'(best)});
         end
         default: ;
      endcase
   endtask

   // Watch the channels on every rising edge.
   always @(posedge clock) begin
      placement_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         base_time_q <= '0;
         worker_count_q <= 4'd8;
         for (int w = 0; w < esp_pkg::WORKERS; w++) begin
            free_time[w] = '0; cache_mask[w] = '0; start_acc[w] = '0; fetch_acc[w] = '0;
         end
         for (int t = 0; t < esp_pkg::TASKS; t++) begin
            task_placed[t] = 1'b0; task_out_size[t] = '0;
            task_finish[t] = '0; task_worker[t] = '0;
         end
         open_index = '0; open_exec = '0; open_missing = 1'b0;
         placements_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == esp_pkg::CSR_BASE_TIME) base_time_q <= csr_wdata;
            else worker_count_q <= csr_wdata[3:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[51:0];
            if (placements_due.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               errs++;
            end else begin
               want = placements_due.pop_front();
               if (got.worker !== want.worker) begin
                  $error("assigned_worker: expected %0d, got %0d", want.worker, got.worker);
                  errs++;
               end
               if (got.finish !== want.finish) begin
                  $error("end_time: expected %0d, got %0d", want.finish, got.finish);
                  errs++;
               end
               if (got.missing !== want.missing) begin
                  $error("missing_dependency: expected %0d, got %0d",
                         want.missing, got.missing);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) apply_request(req_tuser, req_tdata);
         fail_count <= fail_count + errs;
      end
   end

endmodule

// ===== bench/earliest_start_task_placer_tb.sv =====
`timescale 1ns / 100ps

module earliest_start_task_placer_tb;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [55:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [47:0]  csr_wdata = '0;
   int           fail_count;
   int           pending;
   int           idle_cycles = 0;
   bit           long_hold = 1'b0;
   bit           placed_ever [esp_pkg::TASKS];
   bit           sized [esp_pkg::TASKS];

   localparam int IDLE_LIMIT = 20000;

   always #6 clock = ~clock;

   earliest_start_task_placer dut (.*);

   esp_checker checker_i (.*);

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off early in the random phase.
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         rsp_tready <= 1'b0;
         repeat (gap) @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic write_reg(logic idx, logic [47:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every placement has come back and the block has settled.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic send(logic [2:0] func, logic [167:0] d, bit no_gap = 0);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [167:0] load_word(logic [2:0] w, logic [31:0] wt, logic [15:0] m);
      logic [167:0] d;
      d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d[2:0] = w; d[34:3] = wt; d[50:35] = m;
      return d;
   endfunction

   function automatic logic [167:0] begin_word(logic [7:0] t, logic [31:0] ex,
                                               logic [31:0] os, logic first);
      logic [167:0] d;
      d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d[58:51] = t; d[90:59] = ex; d[122:91] = os; d[123] = first;
      return d;
   endfunction

   // A dependency word that names prerequisite p; the other bits are random.
   function automatic logic [167:0] dep_word(logic [7:0] p);
      logic [167:0] d;
      d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d[131:124] = p;
      return d;
   endfunction

   function automatic logic [167:0] model_word(logic [3:0] id, logic [30:0] sz);
      logic [167:0] d;
      d = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      d[135:132] = id; d[166:136] = sz;
      return d;
   endfunction

   function automatic logic [31:0] rand32();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 8);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_prereq();
      int t;
      // A random task that is unplaced or sized; never placed-but-unsized.
      for (int k = 0; k < 20; k++) begin
         t = $urandom_range(0, esp_pkg::TASKS - 1);
         if (!placed_ever[t] || sized[t]) return 8'(t);
      end
      return 8'd255;
   endfunction

   task automatic run_task(int n_deps, int n_models);
      logic [7:0] t;
      t = 8'($urandom_range(0, esp_pkg::TASKS - 1));
      send(esp_pkg::FUNC_BEGIN,
           begin_word(t, rand32(), rand32(), 1'($urandom_range(0, 1))));
      sized[t] = 1'b1;
      repeat (n_deps) send(esp_pkg::FUNC_DEP, dep_word(pick_prereq()));
      repeat (n_models) send(esp_pkg::FUNC_MODEL,
                             model_word(4'($urandom), 31'($urandom >> 1)));
      send(esp_pkg::FUNC_PLACE, load_word(3'($urandom), $urandom, 16'($urandom)));
      placed_ever[t] = 1'b1;
   endtask

   initial begin
      int sent;
      int nd, nm;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: place without begin uses task 0, then extremes.
      send(esp_pkg::FUNC_PLACE, '0);
      placed_ever[0] = 1'b1;
      send(esp_pkg::FUNC_DEP, dep_word(8'd1));
      send(esp_pkg::FUNC_LOAD, load_word(3'd7, 32'hFFFF_FFFF, 16'hFFFF));
      send(esp_pkg::FUNC_LOAD, load_word(3'd0, 32'd0, 16'h0000));
      send(esp_pkg::FUNC_BEGIN, begin_word(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      sized[255] = 1'b1;
      send(esp_pkg::FUNC_MODEL, model_word(4'd15, 31'h7FFF_FFFF));
      send(esp_pkg::FUNC_MODEL, model_word(4'd0, 31'd0));
      send(esp_pkg::FUNC_DEP, dep_word(8'd200));
      send(esp_pkg::FUNC_PLACE, '0);
      placed_ever[255] = 1'b1;
      send(esp_pkg::FUNC_BEGIN, begin_word(8'd1, 32'd0, 32'd3, 1'b0));
      sized[1] = 1'b1;
      send(esp_pkg::FUNC_DEP, dep_word(8'd255));
      send(esp_pkg::FUNC_PLACE, '0);
      placed_ever[1] = 1'b1;
      send(3'd5, '1);
      send(3'd7, '0);
      drain();

      // Saturation with the largest base time and a single worker.
      write_reg(esp_pkg::CSR_BASE_TIME, 48'hFFFF_FFFF_FFFF);
      write_reg(esp_pkg::CSR_WORKER_COUNT, 48'd1);
      send(esp_pkg::FUNC_LOAD, load_word(3'd0, 32'h10, 16'h1));
      run_task(2, 2);
      drain();
      write_reg(esp_pkg::CSR_WORKER_COUNT, 48'd0);
      drain();
      run_task(1, 1);
      drain();
      write_reg(esp_pkg::CSR_WORKER_COUNT, 48'd15);
      write_reg(esp_pkg::CSR_BASE_TIME, 48'd0);

      // Random phases, each under its own register setting.
      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 1) long_hold = 1'b1;
         while (sent < (phase + 1) * 280) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  send(esp_pkg::FUNC_LOAD, load_word(3'($urandom), rand32(), 16'($urandom)));
                  sent++;
               end
               2: begin
                  send(3'($urandom_range(5, 7)),
                       load_word(3'($urandom), $urandom, 16'($urandom)));
                  sent++;
               end
               3: begin
                  send(esp_pkg::FUNC_PLACE,
                       load_word(3'($urandom), $urandom, 16'($urandom)), 1);
                  sent++;
               end
               default: begin
                  nd = $urandom_range(0, 4);
                  nm = $urandom_range(0, 3);
                  run_task(nd, nm);
                  sent += nd + nm + 2;
               end
            endcase
         end
         drain();
         write_reg(esp_pkg::CSR_BASE_TIME, (phase == 4) ? 48'hFFFF_0000_0000 :
                   48'({$urandom_range(0, 255), $urandom}));
         write_reg(esp_pkg::CSR_WORKER_COUNT, 48'($urandom_range(0, 15)));
      end

      drain();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
